### design/ccpp_pkg.sv
// Shared types and codes for the class constant pool parser.
// No dependencies; every module of the block imports this package.
`timescale 1ns / 1ps

package ccpp_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_req;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  event_res;
    logic [15:0] entry_index;
    logic [7:0]  entry_tag;
    logic [15:0] first_index;
    logic [15:0] second_index;
    logic [63:0] value_bits;
    logic [7:0]  payload_byte;
    logic        last_payload;
  } out_beat_t;

  localparam logic [1:0] EV_ENTRY   = 2'd0;
  localparam logic [1:0] EV_PAYLOAD = 2'd1;
  localparam logic [1:0] EV_DONE    = 2'd2;
  localparam logic [1:0] EV_ERROR   = 2'd3;

  localparam logic [7:0] TAG_UTF8      = 8'd1;
  localparam logic [7:0] TAG_INTEGER   = 8'd3;
  localparam logic [7:0] TAG_FLOAT     = 8'd4;
  localparam logic [7:0] TAG_LONG      = 8'd5;
  localparam logic [7:0] TAG_DOUBLE    = 8'd6;
  localparam logic [7:0] TAG_CLASS     = 8'd7;
  localparam logic [7:0] TAG_STRING    = 8'd8;
  localparam logic [7:0] TAG_FIELDREF  = 8'd9;
  localparam logic [7:0] TAG_NAME_TYPE = 8'd12;

  typedef enum logic [6:0] {
    PH_IDLE     = 7'b0000001,
    PH_COUNT_LO = 7'b0000010,
    PH_TAG      = 7'b0000100,
    PH_FIELDS   = 7'b0001000,
    PH_PAYLOAD  = 7'b0010000,
    PH_END      = 7'b0100000,
    PH_HALT     = 7'b1000000
  } phase_t;

endpackage

### design/class_constant_pool_parser.sv
// Constant pool parser: one byte beat in per cycle unless a held result stalls it, at most one result beat out.
// A byte accepted into the input register is decoded combinationally and its result
// beat, if any, is registered in the result register, from which out_data offers it.
// Throughput: one byte per cycle, set by the combinational decode between the
// input register and the result register; a held result with out_ready low stalls both stages.
// Reset (synchronous, rst_n low): both stages empty, parser idle awaiting start.
// Depends on ccpp_pkg, ccpp_in_reg, ccpp_core and ccpp_out_reg.
`timescale 1ns / 1ps

module class_constant_pool_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ccpp_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ccpp_pkg::out_beat_t out_data
);
  import ccpp_pkg::*;

  logic      hold_valid;
  in_beat_t  hold_data;
  logic      can_load;
  logic      take;
  logic      res_vld;
  out_beat_t res;

  assign take = hold_valid && can_load;

  ccpp_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .take       (take),
    .hold_valid (hold_valid),
    .hold_data  (hold_data)
  );

  ccpp_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .item    (hold_data),
    .res_vld (res_vld),
    .res     (res)
  );

  ccpp_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_vld),
    .load_data (res),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### design/ccpp_in_reg.sv
// Input register stage of the constant pool parser.
// Depends on ccpp_pkg for the input beat type.
`timescale 1ns / 1ps

module ccpp_in_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ccpp_pkg::in_beat_t in_data,
  input  logic               take,
  output logic               hold_valid,
  output ccpp_pkg::in_beat_t hold_data
);
  import ccpp_pkg::*;

  logic     vld_r, vld_nxt;
  in_beat_t data_r;

  assign in_ready   = !vld_r || take;
  assign hold_valid = vld_r;
  assign hold_data  = data_r;

  always_comb begin
    vld_nxt = vld_r;
    if (in_valid && in_ready) begin
      vld_nxt = 1'b1;
    end else if (take) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
    if (in_valid && in_ready) begin
      data_r <= in_data;
    end
  end

endmodule

### design/ccpp_core.sv
// Parse state and per-byte decode of the constant pool stream.
// Depends on ccpp_pkg for beat types, event and tag codes and phases.
`timescale 1ns / 1ps

module ccpp_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                take,
  input  ccpp_pkg::in_beat_t  item,
  output logic                res_vld,
  output ccpp_pkg::out_beat_t res
);
  import ccpp_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [15:0] pool_count_r, pool_count_nxt;
  logic [15:0] slot_r, slot_nxt;
  logic [7:0]  tag_r, tag_nxt;
  logic [15:0] left_r, left_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [15:0] held_r, held_nxt;

  logic [7:0]  b;
  logic [16:0] slot_sum;
  logic        end_hit;
  logic [15:0] cnt;
  logic [63:0] acc_sh;
  logic [15:0] left_dec;

  assign b        = item.data_byte;
  assign slot_sum = {1'b0, slot_r} +
                    (((tag_r == TAG_LONG) || (tag_r == TAG_DOUBLE)) ? 17'd2 : 17'd1);
  assign end_hit  = slot_sum >= {1'b0, pool_count_r};
  assign cnt      = {pool_count_r[15:8], b};
  assign acc_sh   = {acc_r[55:0], b};
  assign left_dec = left_r - 16'd1;

  always_comb begin
    phase_nxt      = phase_r;
    pool_count_nxt = pool_count_r;
    slot_nxt       = slot_r;
    tag_nxt        = tag_r;
    left_nxt       = left_r;
    acc_nxt        = acc_r;
    held_nxt       = held_r;
    res_vld        = 1'b0;
    res            = '0;
    if (take) begin
      if (item.start_req) begin
        if (phase_r == PH_END) begin
          res_vld           = 1'b1;
          res.event_res     = EV_DONE;
          res.entry_index   = pool_count_r;
        end
        pool_count_nxt = {b, 8'h00};
        slot_nxt       = '0;
        tag_nxt        = '0;
        left_nxt       = '0;
        acc_nxt        = '0;
        held_nxt       = '0;
        phase_nxt      = PH_COUNT_LO;
      end else begin
        case (phase_r)
          PH_COUNT_LO: begin
            pool_count_nxt = cnt;
            slot_nxt       = 16'd1;
            if (cnt <= 16'd1) begin
              res_vld         = 1'b1;
              res.event_res   = EV_DONE;
              res.entry_index = cnt;
              phase_nxt       = PH_IDLE;
            end else begin
              phase_nxt = PH_TAG;
            end
          end
          PH_TAG: begin
            tag_nxt = b;
            acc_nxt = '0;
            if ((b == TAG_UTF8) || (b == TAG_CLASS) || (b == TAG_STRING)) begin
              left_nxt  = 16'd2;
              phase_nxt = PH_FIELDS;
            end else if ((b == TAG_INTEGER) || (b == TAG_FLOAT) ||
                         ((b >= TAG_FIELDREF) && (b <= TAG_NAME_TYPE))) begin
              left_nxt  = 16'd4;
              phase_nxt = PH_FIELDS;
            end else if ((b == TAG_LONG) || (b == TAG_DOUBLE)) begin
              left_nxt  = 16'd8;
              phase_nxt = PH_FIELDS;
            end else begin
              res_vld         = 1'b1;
              res.event_res   = EV_ERROR;
              res.entry_index = slot_r;
              res.entry_tag   = b;
              phase_nxt       = PH_HALT;
            end
          end
          PH_FIELDS: begin
            acc_nxt  = acc_sh;
            left_nxt = left_dec;
            if (left_dec == 16'd0) begin
              res_vld         = 1'b1;
              res.event_res   = EV_ENTRY;
              res.entry_index = slot_r;
              res.entry_tag   = tag_r;
              slot_nxt        = slot_sum[15:0];
              phase_nxt       = end_hit ? PH_END : PH_TAG;
              if (tag_r == TAG_UTF8) begin
                held_nxt        = acc_sh[15:0];
                res.first_index = acc_sh[15:0];
                if (acc_sh[15:0] != 16'd0) begin
                  left_nxt  = acc_sh[15:0];
                  slot_nxt  = slot_r;
                  phase_nxt = PH_PAYLOAD;
                end
              end else if ((tag_r >= TAG_INTEGER) && (tag_r <= TAG_DOUBLE)) begin
                res.value_bits = acc_sh;
              end else if ((tag_r == TAG_CLASS) || (tag_r == TAG_STRING)) begin
                res.first_index = acc_sh[15:0];
              end else begin
                res.first_index  = acc_sh[31:16];
                res.second_index = acc_sh[15:0];
              end
            end
          end
          PH_PAYLOAD: begin
            res_vld          = 1'b1;
            res.event_res    = EV_PAYLOAD;
            res.entry_index  = slot_r;
            res.entry_tag    = tag_r;
            res.first_index  = held_r;
            res.payload_byte = b;
            res.last_payload = left_r <= 16'd1;
            left_nxt         = left_dec;
            if (left_r <= 16'd1) begin
              slot_nxt  = slot_sum[15:0];
              phase_nxt = end_hit ? PH_END : PH_TAG;
            end
          end
          PH_END: begin
            res_vld         = 1'b1;
            res.event_res   = EV_DONE;
            res.entry_index = pool_count_r;
            phase_nxt       = PH_IDLE;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      pool_count_r <= '0;
      slot_r       <= '0;
      tag_r        <= '0;
      left_r       <= '0;
      acc_r        <= '0;
      held_r       <= '0;
    end else begin
      phase_r      <= phase_nxt;
      pool_count_r <= pool_count_nxt;
      slot_r       <= slot_nxt;
      tag_r        <= tag_nxt;
      left_r       <= left_nxt;
      acc_r        <= acc_nxt;
      held_r       <= held_nxt;
    end
  end

endmodule

### design/ccpp_out_reg.sv
// Result register of the constant pool parser.
// Depends on ccpp_pkg for the result beat type.
`timescale 1ns / 1ps

module ccpp_out_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  ccpp_pkg::out_beat_t load_data,
  output logic                can_load,
  output logic                out_valid,
  input  logic                out_ready,
  output ccpp_pkg::out_beat_t out_data
);
  import ccpp_pkg::*;

  logic      vld_r, vld_nxt;
  out_beat_t data_r;

  assign can_load  = !vld_r || out_ready;
  assign out_valid = vld_r;
  assign out_data  = data_r;

  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (out_ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
    if (load) begin
      data_r <= load_data;
    end
  end

endmodule
